// File: hw/rtl/cfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the 3x3 stream convolution filter.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = 17;   // 8-bit unsigned pixel, zero-extended to 9 bits, times 8-bit signed coefficient
  localparam int SUM_W   = 20;
  localparam int POS_W   = 10;   // width of the centre row / column fields
  localparam int DIM_W   = 13;   // holds any dimension up to 8191
  localparam int TAPS    = 9;
  localparam int MIN_DIM = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd4;

  localparam logic [10:0] RST_IMAGE_DIM = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_COEFF_EDGE = 24'h000100;
  localparam logic [CFG_DATA_W-1:0] RST_COEFF_MID  = 24'h01FC01;

  // Per-pixel bookkeeping that travels with a request down the pipe.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] centre_row;
    logic [POS_W-1:0] centre_col;
  } meta_t;

  // One new window column: rows r-2, r-1 and r at the current column.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] px;
  } column_t;

  typedef logic [TAPS-1:0][COEF_W-1:0] coeff_set_t;

endpackage

// File: hw/rtl/cfs_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_line_buffer
// Two line stores kept as one memory word {row r-2, row r-1} per column.
// ----------------------------------------------------------------------------
module cfs_line_buffer import cfs_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [2*PIX_W-1:0]         wr_data,
  output logic [PIX_W-1:0]           rd_top,
  output logic [PIX_W-1:0]           rd_mid
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] q;
  logic               q_ok;
  // Columns are always visited from 0 upward, so the written entries form a
  // prefix; fill marks its end and anything above it still reads as zero.
  logic [FW-1:0]      fill;
  logic [FW-1:0]      rd_end;

  assign rd_end = FW'(rd_addr) + FW'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      q_ok <= 1'b0;
    end else if (rd_en) begin
      q_ok <= FW'(rd_addr) < fill;
      if (rd_end > fill) begin
        fill <= rd_end;
      end
    end
  end

  assign rd_top = q_ok ? q[2*PIX_W-1:PIX_W] : '0;
  assign rd_mid = q_ok ? q[PIX_W-1:0] : '0;

`ifndef SYNTH
  a_no_same_addr: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("line buffer read and write collide on one column");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill >= $past(fill))
    else $error("line buffer fill mark moved backward");
`endif

endmodule

// File: hw/rtl/cfs_window_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_window_mac
// 3x3 window shift register, nine parallel products, sum and clamp.
// ----------------------------------------------------------------------------
module cfs_window_mac import cfs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  column_t             in_col,
  input  meta_t               in_meta,
  input  coeff_set_t          coeffs,
  output logic                o_valid,
  input  logic                o_ready,
  output logic [SUM_W-1:0]    o_sum,
  output logic [PIX_W-1:0]    o_byte,
  output meta_t               o_meta
);

  logic [PIX_W-1:0]         win [TAPS];
  logic                     s2_valid;
  meta_t                    s2_meta;
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [PROD_W-1:0] prod_next [TAPS];
  logic                     s3_valid;
  meta_t                    s3_meta;
  logic signed [SUM_W-1:0]  part_a, part_b, part_c, sum_next;
  logic [PIX_W-1:0]         byte_next;
  logic                     o_free, s3_free, s2_free;

  assign o_free   = !o_valid || o_ready;
  assign s3_free  = !s3_valid || o_free;
  assign s2_free  = !s2_valid || s3_free;
  assign in_ready = s2_free;

  // Window: shift each row left by one and take in the new column.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (s2_free) begin
      s2_valid <= in_valid;
      if (in_valid) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= in_col.top;
        win[5] <= in_col.mid;
        win[8] <= in_col.px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && in_valid) begin
      s2_meta <= in_meta;
    end
  end

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      prod_next[i] = $signed(PROD_W'({1'b0, win[i]}))
                   * $signed(PROD_W'($signed(coeffs[i])));
    end
  end

  // Products: only windows with a full interior neighbourhood go on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid && s2_meta.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_valid) begin
      prod    <= prod_next;
      s3_meta <= s2_meta;
    end
  end

  always_comb begin
    part_a   = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    part_b   = SUM_W'(prod[3]) + SUM_W'(prod[4]) + SUM_W'(prod[5]);
    part_c   = SUM_W'(prod[6]) + SUM_W'(prod[7]) + SUM_W'(prod[8]);
    sum_next = part_a + part_b + part_c;
    if (sum_next < 0) begin
      byte_next = '0;
    end else if (sum_next > SUM_W'(255)) begin
      byte_next = '1;
    end else begin
      byte_next = sum_next[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && s3_valid) begin
      o_sum  <= sum_next;
      o_byte <= byte_next;
      o_meta <= s3_meta;
    end
  end

`ifndef SYNTH
  a_out_interior: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> o_meta.emit)
    else $error("border pixel reached the result register");
`endif

endmodule

// File: hw/rtl/conv3x3_stream_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_stream_filter
// 3x3 convolution over an 8-bit grayscale pixel stream in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel one per request, row by row. For every
//   pixel at row >= 2 and column >= 2 one result leaves on the m_ channel
//   for the window centre one row up and one column left; border pixels
//   produce nothing. m_tlast marks the last interior result of an image.
//   Throughput is one pixel per clock while m_tready keeps up: the nine
//   products run in parallel and the line stores are one memory read at
//   accept and written when the pixel leaves the input register. A result
//   passes the input/memory read, window shift, products, and sum and clamp
//   registers before it is on m_tdata.
//   When the receiver stalls, the result holds and the pipe keeps accepting
//   pixels until its four stages are full; then s_tready drops.
//   Reset (rst, synchronous) restores the register defaults (1024x1024,
//   Laplacian kernel), empties the pipe and sets the position to row 0,
//   column 0. The line stores need no clearing pass: a fill mark makes
//   unwritten columns read as zero. Write the config port only while idle.
// ----------------------------------------------------------------------------
module conv3x3_stream_filter import cfs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] pixel_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,    // [19:0] filtered_sum, [27:20] filtered_byte,
                                            // [37:28] centre_row, [47:38] centre_col
  output logic                  m_tlast,    // last_of_image
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [10:0]           image_width, image_height;
  logic [CFG_DATA_W-1:0] coeff_top, coeff_mid, coeff_bottom;
  coeff_set_t            coeffs;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] c_now, r_now, c_next, r_next;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic             accept;
  meta_t            meta_now;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  logic [CW-1:0]    s1_col;
  meta_t            s1_meta;
  column_t          s1_column;
  logic [PIX_W-1:0] rd_top, rd_mid;
  logic             mac_ready, s1_move;

  logic [SUM_W-1:0] o_sum;
  logic [PIX_W-1:0] o_byte;
  meta_t            o_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_DIM;
      image_height <= RST_IMAGE_DIM;
      coeff_top    <= RST_COEFF_EDGE;
      coeff_mid    <= RST_COEFF_MID;
      coeff_bottom <= RST_COEFF_EDGE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[10:0];
        REG_COEFF_TOP:    coeff_top    <= cfg_data;
        REG_COEFF_MID:    coeff_mid    <= cfg_data;
        REG_COEFF_BOTTOM: coeff_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coeffs[k]   = coeff_top[8*k +: 8];
      coeffs[k+3] = coeff_mid[8*k +: 8];
      coeffs[k+6] = coeff_bottom[8*k +: 8];
    end
  end

  // Clamp the dimensions in use to 3..MAX.
  always_comb begin
    if (DIM_W'(image_width) < DIM_W'(MIN_DIM)) begin
      w_eff = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(image_width);
    end
    if (DIM_W'(image_height) < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(image_height);
    end
  end

  // Position of this pixel (wrap first if the dimensions shrank) and of the next.
  always_comb begin
    if (DIM_W'(col) >= w_eff) begin
      c_now = '0;
      r_now = DIM_W'(row) + DIM_W'(1);
    end else begin
      c_now = DIM_W'(col);
      r_now = DIM_W'(row);
    end
    if (r_now >= h_eff) begin
      r_now = '0;
    end
    if (c_now + DIM_W'(1) >= w_eff) begin
      c_next = '0;
      r_next = r_now + DIM_W'(1);
      if (r_next >= h_eff) begin
        r_next = '0;
      end
    end else begin
      c_next = c_now + DIM_W'(1);
      r_next = r_now;
    end
    meta_now.emit       = (r_now >= DIM_W'(2)) && (c_now >= DIM_W'(2));
    meta_now.last       = (r_now == h_eff - DIM_W'(1)) && (c_now == w_eff - DIM_W'(1));
    meta_now.centre_row = POS_W'(r_now - DIM_W'(1));
    meta_now.centre_col = POS_W'(c_now - DIM_W'(1));
  end

  assign s_tready = !s1_valid || mac_ready;
  assign accept   = s_tvalid && s_tready;
  assign s1_move  = s1_valid && mac_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (accept) begin
        col <= CW'(c_next);
        row <= RW'(r_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= s_tdata;
      s1_col  <= CW'(c_now);
      s1_meta <= meta_now;
    end
  end

  cfs_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (CW'(c_now)),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data ({rd_mid, s1_px}),
    .rd_top  (rd_top),
    .rd_mid  (rd_mid)
  );

  assign s1_column.top = rd_top;
  assign s1_column.mid = rd_mid;
  assign s1_column.px  = s1_px;

  cfs_window_mac u_window_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_ready (mac_ready),
    .in_col   (s1_column),
    .in_meta  (s1_meta),
    .coeffs   (coeffs),
    .o_valid  (m_tvalid),
    .o_ready  (m_tready),
    .o_sum    (o_sum),
    .o_byte   (o_byte),
    .o_meta   (o_meta)
  );

  assign m_tdata = {o_meta.centre_col, o_meta.centre_row, o_byte, o_sum};
  assign m_tlast = o_meta.last;

`ifndef SYNTH
  a_emit_col: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_meta.emit |-> s1_col >= CW'(2))
    else $error("result flagged for a left border column");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_meta.last |-> s1_meta.emit)
    else $error("end of image flagged on a border pixel");
`endif

endmodule
